>>> rtl/hidms_pkg.sv
// hidms_pkg: shared types and constants for the hid mouse descriptor scan
// payload structs for both channels, scan phase enum, descriptor codes
// no dependencies
`default_nettype none

package hidms_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } hidms_in_t;

  typedef struct packed {
    logic        mouse_found;
    logic        endpoint_found;
    logic [3:0]  endpoint_number;
    logic [15:0] max_packet;
  } hidms_out_t;

  typedef enum logic [1:0] {
    PH_SEEK_IFACE = 2'd0,
    PH_SEEK_EP    = 2'd1,
    PH_STOPPED    = 2'd2
  } hidms_phase_t;

  // descriptor byte offsets
  localparam logic [7:0] OFS_LENGTH    = 8'd0;
  localparam logic [7:0] OFS_KIND      = 8'd1;
  localparam logic [7:0] OFS_EP_ADDR   = 8'd2;
  localparam logic [7:0] OFS_EP_ATTR   = 8'd3;
  localparam logic [7:0] OFS_PKT_LOW   = 8'd4;
  localparam logic [7:0] OFS_CLASS     = 8'd5;
  localparam logic [7:0] OFS_SUBCLASS  = 8'd6;
  localparam logic [7:0] OFS_PROTOCOL  = 8'd7;

  localparam logic [7:0] KIND_INTERFACE    = 8'd4;
  localparam logic [7:0] KIND_ENDPOINT     = 8'd5;
  localparam logic [7:0] HID_CLASS         = 8'd3;
  localparam logic [7:0] BOOT_SUBCLASS     = 8'd1;
  localparam logic [7:0] MOUSE_PROTOCOL    = 8'd2;
  localparam logic [1:0] EP_TYPE_INTERRUPT = 2'd3;
  localparam logic [7:0] IFACE_MIN_LEN     = 8'd9;
  localparam logic [7:0] EP_MIN_LEN        = 8'd7;

endpackage

`default_nettype wire

>>> rtl/usb_hid_mouse_descriptor_scan_unit.sv
// usb_hid_mouse_descriptor_scan_unit: top level of the hid boot mouse descriptor scan
// input register, scan core and result register with valid/stall handshakes
// depends on hidms_pkg and hidms_scan
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+---------------------------
//  in      | sink      | hidms_in_t  in_data   | in_valid / in_stall
//  out     | source    | hidms_out_t out_data  | out_valid / out_stall
//
// one byte per cycle while in_stall is low; a result passes the input register, then the result register
// the input register feeds the scan core, whose state updates as the byte leaves it
// only a final byte waits on the result register; other bytes never stall
// in_stall rises only when a final byte is held behind a stalled, full result register
// synchronous active-high rst clears the scan state and both valid flags
`default_nettype none

module usb_hid_mouse_descriptor_scan_unit import hidms_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire hidms_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output hidms_out_t      out_data
);

  // input register stage
  logic       s1_valid;
  hidms_in_t  s1_data;
  logic       s1_adv;
  hidms_out_t scan_result;

  // a byte moves on unless it is a final byte facing a stalled result
  assign s1_adv   = s1_valid && (!s1_data.final_byte || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // descriptor scan state and result logic
  hidms_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .item   (s1_data),
    .result (scan_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_data.final_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_data.final_byte) begin
      out_data <= scan_result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending result dropped");

  a_ep_implies_mouse: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.endpoint_found) |-> out_data.mouse_found)
    else $error("endpoint reported without mouse");

  a_no_ep_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.endpoint_found) |->
      (out_data.endpoint_number == 4'd0 && out_data.max_packet == 16'd0))
    else $error("endpoint fields nonzero without endpoint");

endmodule

`default_nettype wire

>>> rtl/hidms_scan.sv
// hidms_scan: running descriptor scan state, one byte per step
// gives the result for the step's byte combinationally; clears on the final byte
// depends on hidms_pkg
`default_nettype none

module hidms_scan import hidms_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire hidms_in_t  item,
  output hidms_out_t      result
);

  hidms_phase_t phase, phase_next;
  logic [7:0]  bid, bid_next;
  logic [7:0]  len, len_next;
  logic [7:0]  kind, kind_next;
  logic        imatch, imatch_next;
  logic [7:0]  ep_addr, ep_addr_next;
  logic [7:0]  ep_attr, ep_attr_next;
  logic [7:0]  pkt_low, pkt_low_next;
  logic [1:0]  flags, flags_next;
  logic [3:0]  found_ep, found_ep_next;
  logic [15:0] found_size, found_size_next;
  logic        active;
  logic        end_hit;
  logic [7:0]  b;

  assign b = item.data_byte;

  always_comb begin
    phase_next      = phase;
    bid_next        = bid;
    len_next        = len;
    kind_next       = kind;
    imatch_next     = imatch;
    ep_addr_next    = ep_addr;
    ep_attr_next    = ep_attr;
    pkt_low_next    = pkt_low;
    flags_next      = flags;
    found_ep_next   = found_ep;
    found_size_next = found_size;
    end_hit         = 1'b0;
    active          = (phase == PH_SEEK_IFACE) || (phase == PH_SEEK_EP);
    if (active) begin
      if (bid == OFS_LENGTH && b == 8'd0) begin
        // zero length stops the scan
        phase_next = PH_STOPPED;
      end else begin
        unique case (bid)
          OFS_LENGTH: begin
            len_next    = b;
            kind_next   = 8'd0;
            imatch_next = 1'b0;
          end
          OFS_KIND:     kind_next    = b;
          OFS_EP_ADDR:  ep_addr_next = b;
          OFS_EP_ATTR:  ep_attr_next = b;
          OFS_PKT_LOW:  pkt_low_next = b;
          OFS_CLASS: begin
            imatch_next = (b == HID_CLASS);
            if (phase == PH_SEEK_EP) begin
              found_size_next = {b, pkt_low};
            end
          end
          OFS_SUBCLASS: imatch_next = imatch & (b == BOOT_SUBCLASS);
          OFS_PROTOCOL: imatch_next = imatch & (b == MOUSE_PROTOCOL);
          default: ;
        endcase
        end_hit = ({1'b0, bid} + 9'd1) >= {1'b0, len_next};
        if (end_hit) begin
          bid_next = 8'd0;
          // judge the descriptor on its last byte
          if (phase == PH_SEEK_IFACE) begin
            if (kind_next == KIND_INTERFACE && len_next >= IFACE_MIN_LEN && imatch_next) begin
              flags_next[0] = 1'b1;
              phase_next    = PH_SEEK_EP;
            end
          end else begin
            if (kind_next == KIND_ENDPOINT && len_next >= EP_MIN_LEN && ep_addr_next[7] &&
                ep_attr_next[1:0] == EP_TYPE_INTERRUPT) begin
              flags_next[1] = 1'b1;
              found_ep_next = ep_addr_next[3:0];
              phase_next    = PH_STOPPED;
            end
          end
        end else begin
          bid_next = bid + 8'd1;
        end
      end
    end
    result.mouse_found     = flags_next[0];
    result.endpoint_found  = flags_next[1];
    result.endpoint_number = flags_next[1] ? found_ep_next : 4'd0;
    result.max_packet      = flags_next[1] ? found_size_next : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.final_byte)) begin
      phase  <= PH_SEEK_IFACE;
      bid    <= 8'd0;
      len    <= 8'd0;
      kind   <= 8'd0;
      imatch <= 1'b0;
      flags  <= 2'd0;
    end else if (step) begin
      phase  <= phase_next;
      bid    <= bid_next;
      len    <= len_next;
      kind   <= kind_next;
      imatch <= imatch_next;
      flags  <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ep_addr    <= ep_addr_next;
      ep_attr    <= ep_attr_next;
      pkt_low    <= pkt_low_next;
      found_ep   <= found_ep_next;
      found_size <= found_size_next;
    end
  end

  a_ep_needs_mouse: assert property (@(posedge clk) disable iff (rst)
    flags[1] |-> flags[0])
    else $error("endpoint flag without mouse flag");

  a_seek_iface_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SEEK_IFACE) |-> (flags == 2'd0))
    else $error("flags set while seeking interface");

  a_seek_ep_mouse: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SEEK_EP) |-> (flags == 2'b01))
    else $error("seeking endpoint with wrong flags");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (step && item.final_byte) |=> (phase == PH_SEEK_IFACE && bid == 8'd0))
    else $error("scan not cleared after final byte");

endmodule

`default_nettype wire
